// ===== sv/psd_pkg.sv =====
package psd_pkg;

    localparam int SIDE_W = 27;
    localparam logic [SIDE_W-1:0] SIDE_LIMIT = '1;

    localparam logic [1:0] REG_WINDOW_MS   = 2'd0;
    localparam logic [1:0] REG_SENSITIVITY = 2'd1;
    localparam logic [1:0] REG_MIN_DIAG    = 2'd2;

    typedef struct packed {
        logic [31:0] t;
        logic [31:0] y;
        logic [31:0] x;
    } point_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PR_RD,
        ST_PR_CHK,
        ST_CO_RL,
        ST_CO_RP,
        ST_CO_CMP,
        ST_APPEND,
        ST_EVAL,
        ST_WK_F,
        ST_WK_F2,
        ST_WK_RD,
        ST_WK_D,
        ST_SQ,
        ST_GO,
        ST_WT,
        ST_DG,
        ST_DECIDE,
        ST_FINISH
    } state_t;

    function automatic logic [SIDE_W-1:0] clamp_mag(input logic signed [33:0] v);
        logic [33:0] m;
        m = v[33] ? 34'(-v) : 34'(v);
        return (m > {7'd0, SIDE_LIMIT}) ? SIDE_LIMIT : m[SIDE_W-1:0];
    endfunction

    function automatic logic dir_match(input logic [31:0] a, input logic [31:0] b);
        logic az;
        logic bz;
        az = (a == 32'd0);
        bz = (b == 32'd0);
        return (az && bz) || (!az && !bz && (a[31] == b[31]));
    endfunction

endpackage

// ===== sv/psd_isqrt.sv =====
module psd_isqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] value,
    output logic        done,
    output logic [31:0] root
);

    logic [63:0] rad_reg, rad_next;
    logic [33:0] rem_reg, rem_next;
    logic [31:0] root_reg, root_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [35:0] rem_t;
    logic [35:0] trial;

    always_comb begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_t = {rem_reg, rad_reg[63:62]};
        trial = {2'd0, root_reg, 2'b01};
        if (start) begin
            rad_next  = value;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rad_next = {rad_reg[61:0], 2'b00};
            if (rem_t >= trial) begin
                rem_next  = 34'(rem_t - trial);
                root_next = {root_reg[30:0], 1'b1};
            end else begin
                rem_next  = rem_t[33:0];
                root_next = {root_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== sv/pointer_shake_detector_unit.sv =====
// Each input word is one pointer motion report; exactly one result word follows it.
// The history sits in one single-port RAM of HISTORY_DEPTH points, and the block
// handles one report at a time: it drops expired points one by one, then walks
// the stored points during evaluation with the bit-serial square root (32
// iterations), run once per path segment plus once for the diagonal. A new
// report is accepted while the previous result still waits.
module pointer_shake_detector_unit #(
    parameter int HISTORY_DEPTH = 512
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // delta_x[15:0], delta_y[31:16], time_ms[63:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // shake[0], points_held[10:1], zero[15:11]
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    localparam int AW   = $clog2(HISTORY_DEPTH);
    localparam int CW   = $clog2(HISTORY_DEPTH + 1);
    localparam int PW   = 32 + AW;
    localparam int CMPW = (PW + 8 > 48) ? PW + 8 : 48;

    psd_pkg::point_t mem [HISTORY_DEPTH];
    psd_pkg::point_t rdata_reg;
    logic            mem_re, mem_we;
    logic [AW-1:0]   mem_raddr, mem_waddr;
    psd_pkg::point_t mem_wdata;

    psd_pkg::state_t state_reg, state_next;
    logic [15:0] win_reg, sens_reg, mind_reg;
    logic [31:0] pos_x_reg, pos_x_next, pos_y_reg, pos_y_next;
    logic [31:0] now_reg, now_next;
    logic [AW-1:0] oldest_reg, oldest_next, cur_reg, cur_next;
    logic [CW-1:0] count_reg, count_next, idx_reg, idx_next;
    logic [31:0] last_x_reg, last_x_next, last_y_reg, last_y_next;
    logic [31:0] first_x_reg, first_x_next, first_y_reg, first_y_next;
    logic [31:0] prev_x_reg, prev_x_next, prev_y_reg, prev_y_next;
    logic signed [31:0] lo_x_reg, lo_x_next, hi_x_reg, hi_x_next;
    logic signed [31:0] lo_y_reg, lo_y_next, hi_y_reg, hi_y_next;
    logic [psd_pkg::SIDE_W-1:0] ma_reg, ma_next, mb_reg, mb_next;
    logic [2*psd_pkg::SIDE_W-1:0] sqa_reg, sqa_next, sqb_reg, sqb_next;
    logic [PW-1:0] path_reg, path_next;
    logic [31:0] diag_reg, diag_next;
    logic diag_ph_reg, diag_ph_next;
    logic shake_reg, shake_next;
    logic out_valid_reg, out_valid_next, out_shake_reg, out_shake_next;
    logic [9:0] out_cnt_reg, out_cnt_next;

    logic        sq_start;
    logic [63:0] sq_value;
    logic        sq_done;
    logic [31:0] sq_root;

    logic [AW-1:0] slot_last, slot_prev, slot_app;
    logic signed [31:0] rx, ry;
    logic [CMPW-1:0] lhs, rhs;

    function automatic logic [AW-1:0] wrap_slot(input logic [CW:0] s);
        logic [CW:0] r;
        r = (s >= (CW+1)'(HISTORY_DEPTH)) ? (CW+1)'(s - (CW+1)'(HISTORY_DEPTH)) : s;
        return r[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] inc_slot(input logic [AW-1:0] s);
        return (s == AW'(HISTORY_DEPTH - 1)) ? '0 : AW'(s + AW'(1));
    endfunction

    psd_isqrt u_isqrt (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (sq_start),
        .value  (sq_value),
        .done   (sq_done),
        .root   (sq_root)
    );

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    assign slot_last = wrap_slot((CW+1)'(oldest_reg) + (CW+1)'(count_reg) - (CW+1)'(1));
    assign slot_prev = wrap_slot((CW+1)'(oldest_reg) + (CW+1)'(count_reg) - (CW+1)'(2));
    assign slot_app  = wrap_slot((CW+1)'(oldest_reg) + (CW+1)'(count_reg));
    assign rx = $signed(rdata_reg.x - first_x_reg);
    assign ry = $signed(rdata_reg.y - first_y_reg);
    assign lhs = CMPW'({path_reg, 8'd0});
    assign rhs = CMPW'(sens_reg * diag_reg);

    always_comb begin
        state_next   = state_reg;
        pos_x_next   = pos_x_reg;
        pos_y_next   = pos_y_reg;
        now_next     = now_reg;
        oldest_next  = oldest_reg;
        cur_next     = cur_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        last_x_next  = last_x_reg;
        last_y_next  = last_y_reg;
        first_x_next = first_x_reg;
        first_y_next = first_y_reg;
        prev_x_next  = prev_x_reg;
        prev_y_next  = prev_y_reg;
        lo_x_next    = lo_x_reg;
        hi_x_next    = hi_x_reg;
        lo_y_next    = lo_y_reg;
        hi_y_next    = hi_y_reg;
        ma_next      = ma_reg;
        mb_next      = mb_reg;
        sqa_next     = sqa_reg;
        sqb_next     = sqb_reg;
        path_next    = path_reg;
        diag_next    = diag_reg;
        diag_ph_next = diag_ph_reg;
        shake_next   = shake_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_shake_next = out_shake_reg;
        out_cnt_next   = out_cnt_reg;
        mem_re    = 1'b0;
        mem_raddr = oldest_reg;
        mem_we    = 1'b0;
        mem_waddr = slot_app;
        mem_wdata = '{t: now_reg, y: pos_y_reg, x: pos_x_reg};
        sq_start  = 1'b0;
        sq_value  = {1'b0, 8'(0), 55'({1'b0, sqa_reg} + {1'b0, sqb_reg})} << 8;
        s_tready  = (state_reg == psd_pkg::ST_IDLE);

        case (state_reg)
            psd_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    pos_x_next = pos_x_reg + {{16{s_tdata[15]}}, s_tdata[15:0]};
                    pos_y_next = pos_y_reg + {{16{s_tdata[31]}}, s_tdata[31:16]};
                    now_next   = s_tdata[63:32];
                    shake_next = 1'b0;
                    state_next = psd_pkg::ST_PR_RD;
                end
            end
            psd_pkg::ST_PR_RD: begin
                if (count_reg != '0) begin
                    mem_re     = 1'b1;
                    mem_raddr  = oldest_reg;
                    state_next = psd_pkg::ST_PR_CHK;
                end else begin
                    state_next = psd_pkg::ST_APPEND;
                end
            end
            psd_pkg::ST_PR_CHK: begin
                if ((now_reg - rdata_reg.t) >= {16'd0, win_reg}) begin
                    oldest_next = inc_slot(oldest_reg);
                    count_next  = count_reg - CW'(1);
                    state_next  = psd_pkg::ST_PR_RD;
                end else if (count_reg >= CW'(2)) begin
                    state_next = psd_pkg::ST_CO_RL;
                end else begin
                    state_next = psd_pkg::ST_APPEND;
                end
            end
            psd_pkg::ST_CO_RL: begin
                mem_re     = 1'b1;
                mem_raddr  = slot_last;
                state_next = psd_pkg::ST_CO_RP;
            end
            psd_pkg::ST_CO_RP: begin
                last_x_next = rdata_reg.x;
                last_y_next = rdata_reg.y;
                mem_re      = 1'b1;
                mem_raddr   = slot_prev;
                state_next  = psd_pkg::ST_CO_CMP;
            end
            psd_pkg::ST_CO_CMP: begin
                if (psd_pkg::dir_match(last_x_reg - rdata_reg.x, pos_x_reg - last_x_reg) &&
                    psd_pkg::dir_match(last_y_reg - rdata_reg.y, pos_y_reg - last_y_reg)) begin
                    mem_we     = 1'b1;
                    mem_waddr  = slot_last;
                    state_next = psd_pkg::ST_FINISH;
                end else begin
                    state_next = psd_pkg::ST_APPEND;
                end
            end
            psd_pkg::ST_APPEND: begin
                if (count_reg < CW'(HISTORY_DEPTH)) begin
                    mem_we     = 1'b1;
                    mem_waddr  = slot_app;
                    count_next = count_reg + CW'(1);
                end
                state_next = psd_pkg::ST_EVAL;
            end
            psd_pkg::ST_EVAL: begin
                state_next = (count_reg >= CW'(2)) ? psd_pkg::ST_WK_F : psd_pkg::ST_FINISH;
            end
            psd_pkg::ST_WK_F: begin
                mem_re       = 1'b1;
                mem_raddr    = oldest_reg;
                cur_next     = inc_slot(oldest_reg);
                idx_next     = CW'(1);
                path_next    = '0;
                lo_x_next    = '0;
                hi_x_next    = '0;
                lo_y_next    = '0;
                hi_y_next    = '0;
                diag_ph_next = 1'b0;
                state_next   = psd_pkg::ST_WK_F2;
            end
            psd_pkg::ST_WK_F2: begin
                first_x_next = rdata_reg.x;
                first_y_next = rdata_reg.y;
                prev_x_next  = rdata_reg.x;
                prev_y_next  = rdata_reg.y;
                state_next   = psd_pkg::ST_WK_RD;
            end
            psd_pkg::ST_WK_RD: begin
                mem_re     = 1'b1;
                mem_raddr  = cur_reg;
                state_next = psd_pkg::ST_WK_D;
            end
            psd_pkg::ST_WK_D: begin
                ma_next = psd_pkg::clamp_mag(34'($signed(rdata_reg.x - prev_x_reg)));
                mb_next = psd_pkg::clamp_mag(34'($signed(rdata_reg.y - prev_y_reg)));
                if (rx < lo_x_reg) lo_x_next = rx;
                if (rx > hi_x_reg) hi_x_next = rx;
                if (ry < lo_y_reg) lo_y_next = ry;
                if (ry > hi_y_reg) hi_y_next = ry;
                prev_x_next = rdata_reg.x;
                prev_y_next = rdata_reg.y;
                cur_next    = inc_slot(cur_reg);
                state_next  = psd_pkg::ST_SQ;
            end
            psd_pkg::ST_SQ: begin
                sqa_next   = ma_reg * ma_reg;
                sqb_next   = mb_reg * mb_reg;
                state_next = psd_pkg::ST_GO;
            end
            psd_pkg::ST_GO: begin
                sq_start   = 1'b1;
                state_next = psd_pkg::ST_WT;
            end
            psd_pkg::ST_WT: begin
                if (sq_done) begin
                    if (diag_ph_reg) begin
                        diag_next  = sq_root;
                        state_next = psd_pkg::ST_DECIDE;
                    end else begin
                        path_next = path_reg + PW'(sq_root);
                        idx_next  = idx_reg + CW'(1);
                        if (idx_reg + CW'(1) == count_reg) begin
                            state_next = psd_pkg::ST_DG;
                        end else begin
                            state_next = psd_pkg::ST_WK_RD;
                        end
                    end
                end
            end
            psd_pkg::ST_DG: begin
                ma_next = psd_pkg::clamp_mag(34'(hi_x_reg) - 34'(lo_x_reg));
                mb_next = psd_pkg::clamp_mag(34'(hi_y_reg) - 34'(lo_y_reg));
                diag_ph_next = 1'b1;
                state_next   = psd_pkg::ST_SQ;
            end
            psd_pkg::ST_DECIDE: begin
                if ((diag_reg >= {12'd0, mind_reg, 4'd0}) && (lhs > rhs)) begin
                    shake_next  = 1'b1;
                    count_next  = '0;
                    oldest_next = '0;
                end
                state_next = psd_pkg::ST_FINISH;
            end
            psd_pkg::ST_FINISH: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_shake_next = shake_reg;
                    out_cnt_next   = 10'(count_reg);
                    state_next     = psd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = psd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= psd_pkg::ST_IDLE;
            win_reg       <= 16'd1000;
            sens_reg      <= 16'd1024;
            mind_reg      <= 16'd40;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            oldest_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            oldest_reg    <= oldest_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    psd_pkg::REG_WINDOW_MS:   win_reg  <= cfg_wdata;
                    psd_pkg::REG_SENSITIVITY: sens_reg <= cfg_wdata;
                    psd_pkg::REG_MIN_DIAG:    mind_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
        now_reg     <= now_next;
        cur_reg     <= cur_next;
        idx_reg     <= idx_next;
        last_x_reg  <= last_x_next;
        last_y_reg  <= last_y_next;
        first_x_reg <= first_x_next;
        first_y_reg <= first_y_next;
        prev_x_reg  <= prev_x_next;
        prev_y_reg  <= prev_y_next;
        lo_x_reg    <= lo_x_next;
        hi_x_reg    <= hi_x_next;
        lo_y_reg    <= lo_y_next;
        hi_y_reg    <= hi_y_next;
        ma_reg      <= ma_next;
        mb_reg      <= mb_next;
        sqa_reg     <= sqa_next;
        sqb_reg     <= sqb_next;
        path_reg    <= path_next;
        diag_reg    <= diag_next;
        diag_ph_reg <= diag_ph_next;
        shake_reg   <= shake_next;
        out_shake_reg <= out_shake_next;
        out_cnt_reg   <= out_cnt_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_cnt_reg, out_shake_reg};

endmodule

// ===== sv/psd_checker.sv =====
module psd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word valid right after reset");

    a_shake_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |-> (m_tdata[10:1] == 10'd0))
        else $error("shake reported with history left");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second word taken while the first is in work");

    a_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result word changed");

endmodule

bind pointer_shake_detector_unit psd_checker u_psd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);
